/* rtl/ps2hid_pkg.sv */
`timescale 1ns / 1ps

package ps2hid_pkg;

  localparam int unsigned KEY_SLOTS = 6;
  localparam int unsigned OUT_SLOTS = 6;
  localparam int unsigned SLOT_W    = (KEY_SLOTS > 1) ? $clog2(KEY_SLOTS) : 1;

  localparam logic [15:0] EXT_MASK   = 16'hE000;
  localparam logic [4:0]  MOD_PREFIX = 5'b11100;

  typedef struct packed {
    logic [15:0] event_code;
    logic        is_make;
  } in_t;

  typedef struct packed {
    logic [7:0] modifier_bits;
    logic [7:0] key_slot0;
    logic [7:0] key_slot1;
    logic [7:0] key_slot2;
    logic [7:0] key_slot3;
    logic [7:0] key_slot4;
    logic [7:0] key_slot5;
  } out_t;

  typedef struct packed {
    logic [7:0] usage;
    logic       is_mod;
    logic [2:0] mod_sel;
  } lookup_t;

  function automatic logic [7:0] main_usage(input logic [6:0] code);
    logic [7:0] u;
    case (code)
      7'h01: u = 8'h29; 7'h02: u = 8'h1E; 7'h03: u = 8'h1F; 7'h04: u = 8'h20;
      7'h05: u = 8'h21; 7'h06: u = 8'h22; 7'h07: u = 8'h23; 7'h08: u = 8'h24;
      7'h09: u = 8'h25; 7'h0A: u = 8'h26; 7'h0B: u = 8'h27; 7'h0C: u = 8'h2D;
      7'h0D: u = 8'h2E; 7'h0E: u = 8'h2A; 7'h0F: u = 8'h2B;
      7'h10: u = 8'h14; 7'h11: u = 8'h1A; 7'h12: u = 8'h08; 7'h13: u = 8'h15;
      7'h14: u = 8'h17; 7'h15: u = 8'h1C; 7'h16: u = 8'h18; 7'h17: u = 8'h0C;
      7'h18: u = 8'h12; 7'h19: u = 8'h13; 7'h1A: u = 8'h2F; 7'h1B: u = 8'h30;
      7'h1C: u = 8'h28; 7'h1D: u = 8'hE0; 7'h1E: u = 8'h04; 7'h1F: u = 8'h16;
      7'h20: u = 8'h07; 7'h21: u = 8'h09; 7'h22: u = 8'h0A; 7'h23: u = 8'h0B;
      7'h24: u = 8'h0D; 7'h25: u = 8'h0E; 7'h26: u = 8'h0F; 7'h27: u = 8'h33;
      7'h28: u = 8'h34; 7'h29: u = 8'h35; 7'h2A: u = 8'hE1; 7'h2B: u = 8'h31;
      7'h2C: u = 8'h1D; 7'h2D: u = 8'h1B; 7'h2E: u = 8'h06; 7'h2F: u = 8'h19;
      7'h30: u = 8'h05; 7'h31: u = 8'h11; 7'h32: u = 8'h10; 7'h33: u = 8'h36;
      7'h34: u = 8'h37; 7'h35: u = 8'h38; 7'h36: u = 8'hE5; 7'h37: u = 8'h55;
      7'h38: u = 8'hE2; 7'h39: u = 8'h2C; 7'h3A: u = 8'h39; 7'h3B: u = 8'h3A;
      7'h3C: u = 8'h3B; 7'h3D: u = 8'h3C; 7'h3E: u = 8'h3D; 7'h3F: u = 8'h3E;
      7'h40: u = 8'h3F; 7'h41: u = 8'h40; 7'h42: u = 8'h41; 7'h43: u = 8'h42;
      7'h44: u = 8'h43; 7'h45: u = 8'h53; 7'h46: u = 8'h47; 7'h47: u = 8'h5F;
      7'h48: u = 8'h60; 7'h49: u = 8'h61; 7'h4A: u = 8'h56; 7'h4B: u = 8'h5C;
      7'h4C: u = 8'h5D; 7'h4D: u = 8'h5E; 7'h4E: u = 8'h57; 7'h4F: u = 8'h59;
      7'h50: u = 8'h5A; 7'h51: u = 8'h5B; 7'h52: u = 8'h62; 7'h53: u = 8'h63;
      7'h57: u = 8'h44; 7'h58: u = 8'h45;
      default: u = 8'h00;
    endcase
    return u;
  endfunction

  function automatic logic [7:0] ext_usage(input logic [6:0] code);
    logic [7:0] u;
    case (code)
      7'h1C: u = 8'h58; 7'h1D: u = 8'hE4; 7'h35: u = 8'h54; 7'h38: u = 8'hE6;
      7'h47: u = 8'h4A; 7'h48: u = 8'h52; 7'h49: u = 8'h4B; 7'h4B: u = 8'h50;
      7'h4D: u = 8'h4F; 7'h4F: u = 8'h4D; 7'h50: u = 8'h51; 7'h51: u = 8'h4E;
      7'h52: u = 8'h49; 7'h53: u = 8'h4C;
      default: u = 8'h00;
    endcase
    return u;
  endfunction

endpackage

/* rtl/ps2_to_hid_keyboard_report.sv */
`timescale 1ns / 1ps

// Converts PS/2 set-1 key events into USB HID boot keyboard reports. An event
// is taken when start_i is high while busy_o is low; busy_o then stays high
// until the event is fully handled. A report, if the event changed the held
// modifiers or key list, appears on result_o for exactly one cycle with
// result_valid_o high; the receiver cannot stall it and must take it then.
// Unmapped codes and events that change nothing give no report. One 8-bit
// equality comparator is shared by a small sequencer that walks the key
// slots one per cycle: after the table lookup, the key-list search and, for
// a release, the shift down run over the slots (a modifier event skips
// them), then the modifiers and slots are compared against and copied into
// the last sent report, and a final state presents the report. An unmapped
// code ends the event right after the lookup. A new event can be taken as
// soon as busy_o is low.

module ps2_to_hid_keyboard_report (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  ps2hid_pkg::in_t    cmd_i,
  output logic               busy_o,
  output logic               result_valid_o,
  output ps2hid_pkg::out_t   result_o
);
  import ps2hid_pkg::*;

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_LOOK  = 6'b000010,
    S_SCAN  = 6'b000100,
    S_SHIFT = 6'b001000,
    S_CMP   = 6'b010000,
    S_EMIT  = 6'b100000
  } state_e;

  localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(KEY_SLOTS - 1);

  state_e            state_q, state_d;
  logic [SLOT_W-1:0] idx_q, idx_d;
  lookup_t           lookup, lkp_q;
  logic              make_q;
  logic              diff_q, diff_d;
  logic [7:0]        held_mod_q, held_mod_d;
  logic [7:0]        sent_mod_q, sent_mod_d;
  logic [7:0]        held_q [KEY_SLOTS];
  logic [7:0]        sent_q [KEY_SLOTS];

  logic              accept;
  logic              last;
  logic [SLOT_W-1:0] rd_idx;
  logic [7:0]        rd_data;
  logic [7:0]        cmp_b;
  logic              eq;
  logic              held_we;
  logic [7:0]        held_wdata;
  logic              sent_we;
  logic [7:0]        out_keys [OUT_SLOTS];

  ps2hid_lookup u_lookup (
    .event_code_i (cmd_i.event_code),
    .lookup_o     (lookup)
  );

  assign accept = start_i && !busy_o;
  assign last   = (idx_q == LAST_SLOT);

  // shared slot read port and comparator
  assign rd_idx  = (state_q == S_SHIFT && !last) ? SLOT_W'(idx_q + 1'b1) : idx_q;
  assign rd_data = held_q[rd_idx];
  assign cmp_b   = (state_q == S_SCAN) ? lkp_q.usage : sent_q[idx_q];
  assign eq      = (rd_data == cmp_b);

  always_comb begin
    state_d    = state_q;
    idx_d      = idx_q;
    diff_d     = diff_q;
    held_mod_d = held_mod_q;
    sent_mod_d = sent_mod_q;
    held_we    = 1'b0;
    held_wdata = rd_data;
    sent_we    = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        if (accept) state_d = S_LOOK;
      end
      S_LOOK: begin
        idx_d = '0;
        if (lkp_q.usage == 8'h00) begin
          state_d = S_IDLE;
        end else if (lkp_q.is_mod) begin
          if (make_q) held_mod_d = held_mod_q | (8'h01 << lkp_q.mod_sel);
          else        held_mod_d = held_mod_q & ~(8'h01 << lkp_q.mod_sel);
          state_d = S_CMP;
        end else begin
          state_d = S_SCAN;
        end
      end
      S_SCAN: begin
        if (eq) begin
          if (make_q) begin
            idx_d   = '0;
            state_d = S_CMP;
          end else begin
            state_d = S_SHIFT;
          end
        end else if (rd_data == 8'h00) begin
          // list is packed: first empty slot ends the search
          if (make_q) begin
            held_we    = 1'b1;
            held_wdata = lkp_q.usage;
          end
          idx_d   = '0;
          state_d = S_CMP;
        end else if (last) begin
          idx_d   = '0;
          state_d = S_CMP;
        end else begin
          idx_d = SLOT_W'(idx_q + 1'b1);
        end
      end
      S_SHIFT: begin
        held_we = 1'b1;
        if (last) begin
          held_wdata = 8'h00;
          idx_d      = '0;
          state_d    = S_CMP;
        end else begin
          held_wdata = rd_data;
          idx_d      = SLOT_W'(idx_q + 1'b1);
        end
      end
      S_CMP: begin
        sent_we = 1'b1;
        if (idx_q == '0) begin
          diff_d     = !eq || (held_mod_q != sent_mod_q);
          sent_mod_d = held_mod_q;
        end else begin
          diff_d = diff_q || !eq;
        end
        if (last) state_d = S_EMIT;
        else      idx_d   = SLOT_W'(idx_q + 1'b1);
      end
      S_EMIT: begin
        state_d = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      idx_q      <= '0;
      diff_q     <= 1'b0;
      held_mod_q <= 8'h00;
      sent_mod_q <= 8'h00;
      for (int i = 0; i < KEY_SLOTS; i++) begin
        held_q[i] <= 8'h00;
        sent_q[i] <= 8'h00;
      end
    end else begin
      state_q    <= state_d;
      idx_q      <= idx_d;
      diff_q     <= diff_d;
      held_mod_q <= held_mod_d;
      sent_mod_q <= sent_mod_d;
      if (held_we) held_q[idx_q] <= held_wdata;
      if (sent_we) sent_q[idx_q] <= rd_data;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      lkp_q  <= lookup;
      make_q <= cmd_i.is_make;
    end
  end

  always_comb begin
    for (int k = 0; k < OUT_SLOTS; k++) out_keys[k] = 8'h00;
    for (int k = 0; k < OUT_SLOTS && k < KEY_SLOTS; k++) out_keys[k] = sent_q[k];
  end

  assign busy_o         = (state_q != S_IDLE);
  assign result_valid_o = (state_q == S_EMIT) && diff_q;

  assign result_o.modifier_bits = sent_mod_q;
  assign result_o.key_slot0     = out_keys[0];
  assign result_o.key_slot1     = out_keys[1];
  assign result_o.key_slot2     = out_keys[2];
  assign result_o.key_slot3     = out_keys[3];
  assign result_o.key_slot4     = out_keys[4];
  assign result_o.key_slot5     = out_keys[5];

  a_strobe_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |=> !result_valid_o)
    else $error("result strobe longer than one cycle");

  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |=> busy_o)
    else $error("busy not raised after transfer");

  a_report_mods: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> (result_o.modifier_bits == held_mod_q))
    else $error("reported modifiers differ from held modifiers");

  a_report_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> (busy_o && $past(state_q) == S_CMP))
    else $error("report outside of event handling");

endmodule

/* rtl/ps2hid_lookup.sv */
`timescale 1ns / 1ps

module ps2hid_lookup (
  input  logic [15:0]          event_code_i,
  output ps2hid_pkg::lookup_t  lookup_o
);
  import ps2hid_pkg::*;

  logic       ext;
  logic [7:0] usage;

  assign ext   = |(event_code_i & EXT_MASK);
  assign usage = ext ? ext_usage(event_code_i[6:0]) : main_usage(event_code_i[6:0]);

  assign lookup_o.usage   = usage;
  assign lookup_o.is_mod  = (usage[7:3] == MOD_PREFIX);
  assign lookup_o.mod_sel = usage[2:0];

endmodule
